/* hdl/wbpm_pkg.sv */
// Shared constants, types and helper functions for the wildcard byte pattern matcher.
package wbpm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int PAT_REG_BYTES = 16;
    localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_SEARCH_MODE = 3'd0;
    localparam logic [2:0] REG_PATTERN_LEN = 3'd1;
    localparam logic [2:0] REG_START_OFS = 3'd2;
    localparam logic [2:0] REG_PATTERN_LOW = 3'd3;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd4;
    localparam logic [2:0] REG_CARE_MASK = 3'd5;

    localparam logic [1:0] MODE_PREFIX = 2'd0;
    localparam logic [1:0] MODE_SUFFIX = 2'd1;
    localparam logic [1:0] MODE_OFFSET = 2'd2;
    localparam logic [1:0] MODE_CONTAINS = 2'd3;

    typedef struct packed {
        logic [1:0]  search_mode;
        logic [4:0]  pattern_length;
        logic [15:0] start_offset;
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] care_mask;
    } cfg_t;

    typedef struct packed {
        logic       care;
        logic [7:0] want;
    } cell_ref_t;

    // pattern_length with zero taken as one and clamped to the window depth
    function automatic logic [LEN_W-1:0] used_length(input logic [4:0] pl);
        logic [LEN_W-1:0] n;
        if (pl == 5'd0)
        begin
            n = LEN_W'(1);
        end
        else if (int'(pl) > PATTERN_BYTES)
        begin
            n = LEN_W'(PATTERN_BYTES);
        end
        else
        begin
            n = LEN_W'(pl);
        end
        return n;
    endfunction

    // window entry k is compared with pattern byte n-1-k
    function automatic cell_ref_t cell_ref(input cfg_t c, input logic [LEN_W-1:0] n,
                                           input int k);
        int                          j;
        logic [3:0]                  jsel;
        logic [8*PAT_REG_BYTES-1:0]  pat;
        cell_ref_t                   r;
        j = int'(n) - 1 - k;
        jsel = j[3:0];
        pat = {c.pattern_high, c.pattern_low};
        r.care = (j >= 0) && (j < PAT_REG_BYTES) && c.care_mask[jsel];
        r.want = pat[{jsel, 3'b000} +: 8];
        return r;
    endfunction

endpackage

/* hdl/wbpm_if.sv */
// Valid/ready channel interfaces for the byte stream and the match result.
interface wbpm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbpm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink (input valid, input matched, output ready);
endinterface

/* hdl/wbpm_cfg.sv */
// APB configuration register block.
module wbpm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbpm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wbpm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wbpm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output wbpm_pkg::cfg_t                    cfg
);

    logic [1:0]  search_mode_reg;
    logic [4:0]  pattern_length_reg;
    logic [15:0] start_offset_reg;
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= wbpm_pkg::MODE_PREFIX;
            pattern_length_reg <= 5'd1;
            start_offset_reg <= '0;
            pattern_low_reg <= '0;
            pattern_high_reg <= '0;
            care_mask_reg <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                wbpm_pkg::REG_SEARCH_MODE:  search_mode_reg <= pwdata[1:0];
                wbpm_pkg::REG_PATTERN_LEN:  pattern_length_reg <= pwdata[4:0];
                wbpm_pkg::REG_START_OFS:    start_offset_reg <= pwdata[15:0];
                wbpm_pkg::REG_PATTERN_LOW:  pattern_low_reg <= pwdata;
                wbpm_pkg::REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                wbpm_pkg::REG_CARE_MASK:    care_mask_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            wbpm_pkg::REG_SEARCH_MODE:  prdata = 64'(search_mode_reg);
            wbpm_pkg::REG_PATTERN_LEN:  prdata = 64'(pattern_length_reg);
            wbpm_pkg::REG_START_OFS:    prdata = 64'(start_offset_reg);
            wbpm_pkg::REG_PATTERN_LOW:  prdata = pattern_low_reg;
            wbpm_pkg::REG_PATTERN_HIGH: prdata = pattern_high_reg;
            wbpm_pkg::REG_CARE_MASK:    prdata = 64'(care_mask_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.search_mode = search_mode_reg;
    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.start_offset = start_offset_reg;
    assign cfg.pattern_low = pattern_low_reg;
    assign cfg.pattern_high = pattern_high_reg;
    assign cfg.care_mask = care_mask_reg;

endmodule

/* hdl/wbpm_cell.sv */
// One window cell: holds a byte, passes it on, and compares the byte it receives.
module wbpm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic                 clear,
    input  logic [7:0]           in_byte,
    input  wbpm_pkg::cell_ref_t  ref_byte,
    output logic [7:0]           out_byte,
    output logic                 match
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift_en)
        begin
            byte_reg <= clear ? 8'd0 : in_byte;
        end
    end

    assign out_byte = byte_reg;
    // compare against the byte entering this cell, i.e. the post-shift window
    assign match = !ref_byte.care || (in_byte == ref_byte.want);

endmodule

/* hdl/wildcard_byte_pattern_matcher.sv */
// Top level: byte window chain, position tracking and match result register.
//
//  channel      dir  handshake        payload
//  byte_stream  in   valid/ready      data_byte[7:0], last_byte
//  result       out  valid/ready      matched
//  apb          cfg  psel/penable     paddr[5:0], pwdata/prdata[63:0], pready
//
// One byte per cycle while ready is high; the window cells shift and compare in the transfer cycle.
// The result is registered at the last byte's transfer and is valid from the next cycle.
// The input stalls only on a last byte while an earlier result is still held and not taken.
// Reset clears the window, position, match flag and result valid.
module wildcard_byte_pattern_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    wbpm_byte_if.sink                         byte_stream,
    wbpm_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbpm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wbpm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wbpm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int NB = wbpm_pkg::PATTERN_BYTES;
    localparam int PW = wbpm_pkg::POS_W;

    wbpm_pkg::cfg_t              cfg;
    logic [wbpm_pkg::LEN_W-1:0]  used_len;
    logic [7:0]                  chain_byte [NB+1];
    logic [NB-1:0]               cell_match;
    logic                        in_xfer;
    logic                        clear_win;

    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               pos_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        found_set;
    logic                        hit;
    logic                        match_now;
    logic                        out_valid_reg;
    logic                        matched_reg;

    wbpm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign used_len = wbpm_pkg::used_length(cfg.pattern_length);

    assign byte_stream.ready = !out_valid_reg || result.ready || !byte_stream.last_byte;
    assign in_xfer = byte_stream.valid && byte_stream.ready;
    assign clear_win = byte_stream.last_byte;

    assign chain_byte[0] = byte_stream.data_byte;

    for (genvar k = 0; k < NB; k++)
    begin : g_cell
        wbpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (in_xfer),
            .clear    (clear_win),
            .in_byte  (chain_byte[k]),
            .ref_byte (wbpm_pkg::cell_ref(cfg, used_len, k)),
            .out_byte (chain_byte[k+1]),
            .match    (cell_match[k])
        );
    end

    assign pos_next = (pos_reg == wbpm_pkg::POS_MAX) ? pos_reg : pos_reg + PW'(1);
    assign hit = (pos_next >= PW'(used_len)) && (&cell_match);

    always_comb
    begin
        case (cfg.search_mode)
            wbpm_pkg::MODE_PREFIX:   found_set = hit && (pos_next == PW'(used_len));
            wbpm_pkg::MODE_SUFFIX:   found_set = 1'b0;
            wbpm_pkg::MODE_OFFSET:
                found_set = hit && (pos_next == PW'(cfg.start_offset) + PW'(used_len));
            wbpm_pkg::MODE_CONTAINS: found_set = hit;
            default:                 found_set = 1'b0;
        endcase
    end

    assign found_next = found_reg || found_set;
    // suffix looks only at the window ending on the last byte
    assign match_now = (cfg.search_mode == wbpm_pkg::MODE_SUFFIX) ? hit : found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && byte_stream.last_byte)
            begin
                pos_reg <= '0;
                found_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (in_xfer)
                begin
                    pos_reg <= pos_next;
                    found_reg <= found_next;
                end
                if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && byte_stream.last_byte)
        begin
            matched_reg <= match_now;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.matched = matched_reg;

endmodule

/* dv/wbpm_match_checker.sv */
// Checker: watches the byte, result and APB ports, predicts each match verdict and compares.
module wbpm_match_checker
    import wbpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    wbpm_byte_if                   bytes_in,
    wbpm_result_if                 verdicts,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    input  logic                   pready,
    output int                     fail_count,
    output int                     pending
);

    cfg_t             regs;
    logic [7:0]       window [PATTERN_BYTES];
    logic [POS_W-1:0] pos;
    logic             found;
    logic             match_verdicts_q [$];

    function automatic int clamp_length(input logic [4:0] pl);
        int n;
        n = int'(pl);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > PATTERN_BYTES)
        begin
            n = PATTERN_BYTES;
        end
        return n;
    endfunction

    // pattern byte i lines up with the byte n-1-i transfers before the newest
    function automatic logic window_hit(input int n);
        logic [127:0] pat;
        logic         ok;
        int           i;
        pat = {regs.pattern_high, regs.pattern_low};
        ok = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (i < 16 && regs.care_mask[i] && window[n - 1 - i] != pat[8 * i +: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic void clear_buffer();
        int k;
        for (k = 0; k < PATTERN_BYTES; k++)
        begin
            window[k] = 8'h00;
        end
        pos = '0;
        found = 1'b0;
    endfunction

    // shift one byte in and return the verdict the buffer would get if it ended here
    function automatic logic advance_buffer(input logic [7:0] b);
        int               n;
        int               k;
        logic [POS_W-1:0] npos;
        logic             hit;
        logic             verdict;
        n = clamp_length(regs.pattern_length);
        for (k = PATTERN_BYTES - 1; k > 0; k--)
        begin
            window[k] = window[k - 1];
        end
        window[0] = b;
        npos = (pos == POS_MAX) ? pos : pos + 1'b1;
        pos = npos;
        hit = (int'(npos) >= n) && window_hit(n);
        case (regs.search_mode)
            MODE_PREFIX:
            begin
                if (hit && int'(npos) == n)
                begin
                    found = 1'b1;
                end
                verdict = found;
            end
            MODE_SUFFIX:
            begin
                verdict = hit;
            end
            MODE_OFFSET:
            begin
                if (hit && int'(npos) == int'(regs.start_offset) + n)
                begin
                    found = 1'b1;
                end
                verdict = found;
            end
            default:
            begin
                if (hit)
                begin
                    found = 1'b1;
                end
                verdict = found;
            end
        endcase
        return verdict;
    endfunction

    task automatic flag_failure(input string what, input logic want, input logic got);
        if (fail_count < 10)
        begin
            $display("match checker: %s: expected matched=%0b, got %0b", what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.search_mode = MODE_PREFIX;
            regs.pattern_length = 5'd1;
            regs.start_offset = 16'd0;
            regs.pattern_low = 64'd0;
            regs.pattern_high = 64'd0;
            regs.care_mask = 16'hFFFF;
            clear_buffer();
            match_verdicts_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // result side first, so a verdict never meets one queued at the same edge
            if (verdicts.valid && verdicts.ready)
            begin
                if (match_verdicts_q.size() == 0)
                begin
                    flag_failure("result transfer with none pending", 1'bx, verdicts.matched);
                end
                else
                begin
                    if (verdicts.matched !== match_verdicts_q[0])
                    begin
                        flag_failure("wrong verdict", match_verdicts_q[0], verdicts.matched);
                    end
                    void'(match_verdicts_q.pop_front());
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_SEARCH_MODE:  regs.search_mode = pwdata[1:0];
                    REG_PATTERN_LEN:  regs.pattern_length = pwdata[4:0];
                    REG_START_OFS:    regs.start_offset = pwdata[15:0];
                    REG_PATTERN_LOW:  regs.pattern_low = pwdata;
                    REG_PATTERN_HIGH: regs.pattern_high = pwdata;
                    REG_CARE_MASK:    regs.care_mask = pwdata[15:0];
                    default:          ;
                endcase
            end
            if (bytes_in.valid && bytes_in.ready)
            begin
                if (bytes_in.last_byte)
                begin
                    match_verdicts_q.insert(match_verdicts_q.size(),
                                            advance_buffer(bytes_in.data_byte));
                    clear_buffer();
                end
                else
                begin
                    void'(advance_buffer(bytes_in.data_byte));
                end
            end
            pending = match_verdicts_q.size();
        end
    end

endmodule

/* dv/wildcard_byte_pattern_matcher_tb.sv */
// Testbench top: clock, reset, byte and register stimulus, result backpressure and verdict.
module wildcard_byte_pattern_matcher_tb;
    import wbpm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TOTAL_ITEMS = 1200;
    localparam int HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    // stimulus mirror of the settings, used only to plant patterns and size buffers
    logic [1:0]            cur_mode;
    int                    cur_n;
    int                    cur_ofs;
    logic [7:0]            cur_pat [16];
    logic [15:0]           cur_mask;

    logic                  idle_on;
    logic                  long_hold_req;
    logic                  open_buf;
    int                    items_sent;

    wbpm_byte_if   byte_ch ();
    wbpm_result_if res_ch ();

    wildcard_byte_pattern_matcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_ch),
        .result      (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    wbpm_match_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes_in   (byte_ch),
        .verdicts   (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req <= 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("wildcard_byte_pattern_matcher_tb: done, errors");
        $finish;
    end

    // leaves valid high after the transfer; the next call or stop_sending follows
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [4:0] len,
                                  input logic [15:0] ofs, input logic [63:0] lo,
                                  input logic [63:0] hi, input logic [15:0] mask);
        int k;
        stop_sending();
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        reg_write(REG_SEARCH_MODE, 64'(mode));
        reg_write(REG_PATTERN_LEN, 64'(len));
        reg_write(REG_START_OFS, 64'(ofs));
        reg_write(REG_PATTERN_LOW, lo);
        reg_write(REG_PATTERN_HIGH, hi);
        reg_write(REG_CARE_MASK, 64'(mask));
        cur_mode = mode;
        cur_n = (len == 5'd0) ? 1 : ((int'(len) > 16) ? 16 : int'(len));
        cur_ofs = int'(ofs);
        cur_mask = mask;
        for (k = 0; k < 8; k++)
        begin
            cur_pat[k] = lo[8 * k +: 8];
            cur_pat[k + 8] = hi[8 * k +: 8];
        end
    endtask

    // mostly buffers with the pattern planted where the mode looks, some corrupted
    task automatic send_random_buffer(input logic close);
        logic [7:0] bytes_q [$];
        int         len;
        int         at;
        int         k;
        if (cur_mode == MODE_OFFSET && cur_ofs < 40)
        begin
            len = cur_ofs + cur_n + $urandom_range(0, 6) - 2;
        end
        else
        begin
            len = $urandom_range(1, cur_n + 10);
        end
        if (len < 1)
        begin
            len = 1;
        end
        for (k = 0; k < len; k++)
        begin
            bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case (cur_mode)
                MODE_PREFIX: at = 0;
                MODE_SUFFIX: at = len - cur_n;
                MODE_OFFSET: at = cur_ofs;
                default:     at = (len >= cur_n) ? $urandom_range(0, len - cur_n) : 0;
            endcase
            for (k = 0; k < cur_n; k++)
            begin
                if (at + k >= 0 && at + k < len && cur_mask[k])
                begin
                    bytes_q[at + k] = cur_pat[k];
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                bytes_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            end
        end
        for (k = 0; k < len; k++)
        begin
            push_byte(bytes_q[k], close && (k == len - 1));
        end
        open_buf = !close;
    endtask

    // one long buffer: a lead byte, then fill bytes up to count
    task automatic send_run(input logic [7:0] lead, input logic [7:0] fill, input int count);
        int k;
        push_byte(lead, 1'b0);
        for (k = 1; k < count; k++)
        begin
            push_byte(fill, k == count - 1);
        end
    endtask

    initial
    begin
        int          phase;
        int          nbuf;
        int          b;
        logic [1:0]  r_mode;
        logic [4:0]  r_len;
        logic [15:0] r_ofs;
        logic [15:0] r_mask;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        open_buf = 1'b0;
        items_sent = 0;
        cur_mode = MODE_PREFIX;
        cur_n = 1;
        cur_ofs = 0;
        cur_mask = 16'hFFFF;
        for (b = 0; b < 16; b++)
        begin
            cur_pat[b] = 8'h00;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset: prefix, one byte, pattern 0x00
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // zero length acts as one
        apply_settings(MODE_PREFIX, 5'd0, 16'd0, 64'h00000000_000000FF, {64{1'b1}}, 16'hFFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        // length clamps to 16; a short buffer fails even when all bytes are wild
        apply_settings(MODE_SUFFIX, 5'd31, 16'd0, {64{1'b1}}, {64{1'b1}}, 16'h0000);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b1);
        // offset far past any short buffer
        apply_settings(MODE_OFFSET, 5'd1, 16'hFFFF, 64'd0, 64'd0, 16'h0000);
        push_byte(8'hAA, 1'b1);
        // contains, pattern byte 1 wild
        apply_settings(MODE_CONTAINS, 5'd2, 16'd0, 64'h3412, 64'd0, 16'h0001);
        push_byte(8'h55, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'h00, 1'b1);
        // settings change mid-buffer: the flag found under contains carries into prefix
        apply_settings(MODE_CONTAINS, 5'd1, 16'd0, 64'h77, 64'd0, 16'hFFFF);
        push_byte(8'h77, 1'b0);
        push_byte(8'h01, 1'b0);
        apply_settings(MODE_PREFIX, 5'd1, 16'd0, 64'h00, 64'd0, 16'hFFFF);
        push_byte(8'h02, 1'b1);
        // offset window over positions 2 and 3
        apply_settings(MODE_OFFSET, 5'd2, 16'd2, 64'hCDAB, 64'd0, 16'hFFFF);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hEE, 1'b1);

        // idling stops once the random part is nearly done
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            phase++;
            r_mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       r_len = 5'd0;
                1:       r_len = 5'($urandom_range(17, 31));
                2:       r_len = 5'd16;
                default: r_len = 5'($urandom_range(1, 16));
            endcase
            r_ofs = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 24));
            case ($urandom_range(0, 7))
                0, 1:    r_mask = 16'hFFFF;
                2:       r_mask = 16'h0000;
                default: r_mask = 16'($urandom_range(0, 65535));
            endcase
            apply_settings(r_mode, r_len, r_ofs, {$urandom, $urandom}, {$urandom, $urandom},
                           r_mask);
            idle_on <= (items_sent < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (phase == 4)
            begin
                long_hold_req <= 1'b1;
            end
            nbuf = $urandom_range(3, 12);
            for (b = 0; b < nbuf; b++)
            begin
                send_random_buffer(!(b == nbuf - 1 && $urandom_range(0, 7) == 0));
            end
        end

        // closing part, no idling: longer buffers of repeated bytes
        idle_on <= 1'b0;
        if (open_buf)
        begin
            push_byte(8'h3C, 1'b1);
        end
        apply_settings(MODE_PREFIX, 5'd2, 16'd0, {8{8'h5A}}, {8{8'h5A}}, 16'hFFFF);
        send_run(8'h00, 8'h5A, 40);
        apply_settings(MODE_SUFFIX, 5'd16, 16'd0, {8{8'h5A}}, {8{8'h5A}}, 16'hFFFF);
        send_run(8'h00, 8'h5A, 40);
        apply_settings(MODE_OFFSET, 5'd1, 16'd30, {8{8'h5A}}, {8{8'h5A}}, 16'hFFFF);
        send_run(8'h00, 8'h5A, 40);

        stop_sending();
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("wildcard_byte_pattern_matcher_tb: done, clean");
        end
        else
        begin
            $display("wildcard_byte_pattern_matcher_tb: done, errors");
        end
        $finish;
    end

endmodule
